### rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_DONE    = 3'd1;
  localparam logic [2:0] KIND_BADHEX  = 3'd2;
  localparam logic [2:0] KIND_NOQUOTE = 3'd3;
  localparam logic [2:0] KIND_ENDED   = 3'd4;

  // One decoded input byte: an optional flushed surrogate, an optional code point or raw
  // byte, and an optional terminal result, given out in that order.
  typedef struct packed {
    logic        a_valid;
    logic [15:0] a_cp;
    logic        b_valid;
    logic        b_raw;
    logic [20:0] b_cp;
    logic        term_valid;
    logic [2:0]  term_kind;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/jsu_front.sv
`default_nettype none

module jsu_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  wire  [7:0]       in_byte,
  input  wire              end_of_input,
  output logic             push,
  output jsu_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] pending, pending_next;
  logic [4:0]  hex_digit;
  logic [3:0]  hv;
  logic        hex_ok;
  logic [15:0] code;
  logic        flush;
  logic        is_ws;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign hex_digit = hex_value(in_byte);
  assign hex_ok    = ~hex_digit[4];
  assign hv        = hex_digit[3:0];
  assign code  = {hex_accum[11:0], hv};
  assign flush = (pending != 16'h0000);
  assign is_ws = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                 (in_byte == CH_LF) || (in_byte == CH_CR);

  always_comb begin
    logic clear;
    clear          = 1'b0;
    mode_next      = mode;
    hex_count_next = hex_count;
    hex_accum_next = hex_accum;
    pending_next   = pending;
    cmd            = '0;
    if (end_of_input) begin
      cmd.term_valid = 1'b1;
      cmd.term_kind  = jsu_pkg::KIND_ENDED;
      clear          = 1'b1;
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            mode_next = MODE_BODY;
          end else if (!is_ws) begin
            cmd.term_valid = 1'b1;
            cmd.term_kind  = jsu_pkg::KIND_NOQUOTE;
            clear          = 1'b1;
          end
        end
        MODE_BODY: begin
          if (in_byte != CH_BSL) begin
            cmd.a_valid  = flush;
            cmd.a_cp     = pending;
            pending_next = '0;
          end
          if (in_byte == CH_QUOTE) begin
            cmd.term_valid = 1'b1;
            cmd.term_kind  = jsu_pkg::KIND_DONE;
            clear          = 1'b1;
          end else if (in_byte == CH_BSL) begin
            mode_next = MODE_ESC;
          end else begin
            cmd.b_valid = 1'b1;
            cmd.b_raw   = 1'b1;
            cmd.b_cp    = {13'd0, in_byte};
          end
        end
        MODE_ESC: begin
          mode_next = MODE_BODY;
          if (in_byte != CH_U) begin
            cmd.a_valid  = flush;
            cmd.a_cp     = pending;
            pending_next = '0;
            cmd.b_valid  = 1'b1;
            cmd.b_raw    = 1'b1;
          end
          unique case (in_byte)
            CH_B:    cmd.b_cp = 21'h08;
            CH_F:    cmd.b_cp = 21'h0c;
            CH_N:    cmd.b_cp = 21'h0a;
            CH_R:    cmd.b_cp = 21'h0d;
            CH_T:    cmd.b_cp = 21'h09;
            CH_U: begin
              mode_next      = MODE_HEX;
              hex_count_next = '0;
              hex_accum_next = '0;
            end
            default: cmd.b_cp = {13'd0, in_byte};
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            cmd.term_valid = 1'b1;
            cmd.term_kind  = jsu_pkg::KIND_BADHEX;
            clear          = 1'b1;
          end else if (hex_count == 2'd3) begin
            hex_count_next = '0;
            hex_accum_next = '0;
            mode_next      = MODE_BODY;
            if (flush && code[15:10] == 6'b110111) begin
              cmd.b_valid  = 1'b1;
              cmd.b_cp     = 21'h10000 | {1'b0, pending[9:0], code[9:0]};
              pending_next = '0;
            end else begin
              cmd.a_valid  = flush;
              cmd.a_cp     = pending;
              pending_next = '0;
              if (code[15:10] == 6'b110110) begin
                pending_next = code;
              end else begin
                cmd.b_valid = 1'b1;
                cmd.b_cp    = {5'd0, code};
              end
            end
          end else begin
            hex_accum_next = code;
            hex_count_next = hex_count + 2'd1;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end
    if (clear) begin
      mode_next      = MODE_IDLE;
      hex_count_next = '0;
      hex_accum_next = '0;
      pending_next   = '0;
    end
  end

  assign push = accept && (cmd.a_valid || cmd.b_valid || cmd.term_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      hex_count <= '0;
      hex_accum <= '0;
      pending   <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      hex_accum <= hex_accum_next;
      pending   <= pending_next;
    end
  end

  a_pending_is_high: assert property (@(posedge clk) disable iff (rst)
    (pending != 16'h0000) |-> (pending[15:10] == 6'b110110))
    else $error("stored surrogate is not a high surrogate");

  a_count_outside_hex: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_HEX) |-> (hex_count == 2'd0))
    else $error("hex digit count left over outside a unicode escape");

endmodule

`default_nettype wire

### rtl/jsu_queue.sv
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  jsu_pkg::cmd_t    push_cmd,
  input  wire              pop,
  output jsu_pkg::cmd_t    head,
  output logic             nonempty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("transaction pushed into a full queue");

endmodule

`default_nettype wire

### rtl/jsu_back.sv
`default_nettype none

module jsu_back (
  input  wire              clk,
  input  wire              rst,
  input  jsu_pkg::cmd_t    head,
  input  wire              nonempty,
  output logic             pop,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [7:0]       m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      len;
  } utf8_t;

  function automatic utf8_t encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len      = 4'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len      = 4'd2;
      r.bytes[0] = 8'hc0 | {3'd0, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'd0, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len      = 4'd3;
      r.bytes[0] = 8'he0 | {4'd0, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'd0, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'd0, cp[5:0]};
    end else begin
      r.len      = 4'd4;
      r.bytes[0] = 8'hf0 | {5'd0, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'd0, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'd0, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'd0, cp[5:0]};
    end
    return r;
  endfunction

  utf8_t      enc_a, enc_b;
  logic [3:0] len_a, len_b, len_ab, total, idx4, off;
  logic [2:0] idx;
  logic [7:0] sel_byte;
  logic [2:0] sel_kind;
  logic       sel_last;
  logic       load;

  assign enc_a  = encode({5'd0, head.a_cp});
  assign enc_b  = encode(head.b_cp);
  assign len_a  = head.a_valid ? enc_a.len : 4'd0;
  assign len_b  = head.b_valid ? (head.b_raw ? 4'd1 : enc_b.len) : 4'd0;
  assign len_ab = len_a + len_b;
  assign total  = len_ab + {3'd0, head.term_valid};
  assign idx4   = {1'b0, idx};
  assign off    = idx4 - len_a;

  always_comb begin
    sel_byte = '0;
    sel_kind = jsu_pkg::KIND_DATA;
    if (idx4 < len_a) begin
      sel_byte = enc_a.bytes[idx[1:0]];
    end else if (idx4 < len_ab) begin
      sel_byte = head.b_raw ? head.b_cp[7:0] : enc_b.bytes[off[1:0]];
    end else begin
      sel_kind = head.term_kind;
    end
  end

  assign sel_last = (idx4 == total - 4'd1);
  assign load     = nonempty && (!m_tvalid || m_tready);
  assign pop      = load && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= nonempty;
      end
      if (load) begin
        idx <= sel_last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sel_byte;
      m_tuser <= sel_kind;
      m_tlast <= sel_last;
    end
  end

  a_terminal_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != jsu_pkg::KIND_DATA) |-> m_tlast)
    else $error("terminal result is not the last of its transaction");

  a_terminal_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != jsu_pkg::KIND_DATA) |-> (m_tdata == 8'h00))
    else $error("terminal result carries a data byte");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    nonempty |-> (idx4 < total))
    else $error("result index runs past the queued command");

endmodule

`default_nettype wire

### rtl/json_string_unescape_utf8.sv
// JSON string unescaper producing UTF-8.
// The slave channel takes one byte of JSON text per transaction; s_tuser flags the end
// of input, in which case s_tdata is ignored. The master channel gives the results one
// per transaction: m_tdata is a decoded byte, m_tuser the kind of result (data, string
// done, bad hex digit, no opening quote, input ended) and m_tlast marks the final result
// caused by one input byte. An input byte may cause no result or up to six.
// A front stage decodes each accepted byte into a command in the same cycle and writes
// it into a queue of QUEUE_DEPTH entries; a back stage expands the command at the queue
// head into result bytes, one per cycle unless the receiver stalls, into the output register.
// The results of a byte pass through the queue and then the output register. A byte is
// accepted every cycle while the queue has room, so a stream whose bytes give at most
// one result each runs at one byte per cycle while the receiver is ready; a byte with
// several results holds the output until all are out; the queue absorbs such bursts.
// When the receiver stalls, the output register holds its result, the queue fills and
// s_tready falls once it is full. Reset empties the queue and the output register and
// returns the decoder to waiting for an opening quote, with no surrogate pending.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // in_byte
  input  wire  [0:0] s_tuser,   // end_of_input
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [2:0] m_tuser,   // kind
  output logic       m_tlast
);

  jsu_pkg::cmd_t push_cmd, head;
  logic          accept, push, pop, nonempty, full;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (s_tdata),
    .end_of_input (s_tuser[0]),
    .push         (push),
    .cmd          (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .full     (full)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTE_TARGET = 410;
  localparam int PLAN_LEN = 35;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0c;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_BODY,
    SCAN_ESC,
    SCAN_HEX
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] code;
    logic       eoi;
    logic       typed;
    logic       one;
    logic [7:0] xb;
    logic [2:0] xk;
  } row_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [0:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  scan_mode_t  scan;
  logic [1:0]  digits_seen;
  logic [15:0] hex_acc;
  logic [15:0] held_high;

  result_t step_q[$];
  result_t due_q[$];
  result_t got;
  result_t want;

  int  bytes_sent = 0;
  int  results_seen = 0;
  int  strings_done = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  steady = 1'b0;

  // Directed stream: rows with typed = 1 carry their own expectation.
  row_t plan [PLAN_LEN] = '{
    '{8'h00,     1'b1, 1'b1, 1'b1, 8'h00,    jsu_pkg::KIND_ENDED},
    '{8'h78,     1'b0, 1'b1, 1'b1, 8'h00,    jsu_pkg::KIND_NOQUOTE},
    '{CH_LF,     1'b0, 1'b1, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h01,     1'b0, 1'b1, 1'b1, 8'h01,    jsu_pkg::KIND_DATA},
    '{8'hff,     1'b0, 1'b1, 1'b1, 8'hff,    jsu_pkg::KIND_DATA},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_B,      1'b0, 1'b1, 1'b1, CTL_BS,   jsu_pkg::KIND_DATA},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b1, CH_QUOTE, jsu_pkg::KIND_DATA},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_U,      1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h44,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h38,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h30,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h30,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_U,      1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h64,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h63,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h30,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h30,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_U,      1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h67,     1'b0, 1'b1, 1'b1, 8'h00,    jsu_pkg::KIND_BADHEX},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{CH_U,      1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h64,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h62,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h66,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'h66,     1'b0, 1'b0, 1'b0, 8'h00,    jsu_pkg::KIND_DATA},
    '{8'hff,     1'b1, 1'b1, 1'b1, 8'h00,    jsu_pkg::KIND_ENDED}
  };

  json_string_unescape_utf8 i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void clear_scan();
    scan = SCAN_IDLE;
    digits_seen = 2'd0;
    hex_acc = 16'h0000;
    held_high = 16'h0000;
  endfunction

  function automatic void put_result(input logic [2:0] k, input logic [7:0] b);
    step_q.push_back('{(k == jsu_pkg::KIND_DATA) ? b : 8'h00, k, 1'b0});
  endfunction

  function automatic void put_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_result(jsu_pkg::KIND_DATA, cp[7:0]);
    end else if (cp < 21'h800) begin
      put_result(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_result(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]});
    end else begin
      put_result(jsu_pkg::KIND_DATA, {5'b11110, cp[20:18]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[17:12]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]});
    end
  endfunction

  function automatic void flush_high();
    if (held_high != 16'h0000) begin
      put_utf8({5'b00000, held_high});
      held_high = 16'h0000;
    end
  endfunction

  // Works out the results of one accepted byte into step_q.
  function automatic void unescape_byte(input logic [7:0] c, input logic eoi);
    int          nib;
    logic [15:0] code;
    bit          joined;
    step_q.delete();
    if (eoi) begin
      put_result(jsu_pkg::KIND_ENDED, 8'h00);
      clear_scan();
    end else begin
      case (scan)
        SCAN_IDLE: begin
          if (c == CH_QUOTE) begin
            scan = SCAN_BODY;
          end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF && c != CH_CR) begin
            put_result(jsu_pkg::KIND_NOQUOTE, 8'h00);
            clear_scan();
          end
        end
        SCAN_BODY: begin
          if (c != CH_BSLASH) flush_high();
          if (c == CH_QUOTE) begin
            put_result(jsu_pkg::KIND_DONE, 8'h00);
            clear_scan();
          end else if (c == CH_BSLASH) begin
            scan = SCAN_ESC;
          end else begin
            put_result(jsu_pkg::KIND_DATA, c);
          end
        end
        SCAN_ESC: begin
          if (c != CH_U) flush_high();
          scan = SCAN_BODY;
          case (c)
            CH_B: put_result(jsu_pkg::KIND_DATA, CTL_BS);
            CH_F: put_result(jsu_pkg::KIND_DATA, CTL_FF);
            CH_N: put_result(jsu_pkg::KIND_DATA, CH_LF);
            CH_R: put_result(jsu_pkg::KIND_DATA, CH_CR);
            CH_T: put_result(jsu_pkg::KIND_DATA, CH_TAB);
            CH_U: begin
              scan = SCAN_HEX;
              digits_seen = 2'd0;
              hex_acc = 16'h0000;
            end
            default: put_result(jsu_pkg::KIND_DATA, c);
          endcase
        end
        default: begin
          nib = hex_nibble(c);
          if (nib < 0) begin
            put_result(jsu_pkg::KIND_BADHEX, 8'h00);
            clear_scan();
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (digits_seen == 2'd3) begin
              code = hex_acc;
              joined = 1'b0;
              digits_seen = 2'd0;
              hex_acc = 16'h0000;
              scan = SCAN_BODY;
              if (held_high != 16'h0000) begin
                if (code >= 16'hdc00 && code < 16'he000) begin
                  put_utf8(21'h10000 | {1'b0, held_high[9:0], code[9:0]});
                  held_high = 16'h0000;
                  joined = 1'b1;
                end else begin
                  flush_high();
                end
              end
              if (!joined) begin
                if (code >= 16'hd800 && code < 16'hdc00) held_high = code;
                else put_utf8({5'b00000, code});
              end
            end else begin
              digits_seen = digits_seen + 2'd1;
            end
          end
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  function automatic int pause_cycles();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    gap = pause_cycles();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= eoi;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    unescape_byte(b, eoi);
  endtask

  function automatic void queue_step();
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endfunction

  task automatic send_text(input logic [7:0] b);
    send_byte(b, 1'b0);
    queue_step();
  endtask

  task automatic send_end(input logic [7:0] b);
    send_byte(b, 1'b1);
    queue_step();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return 8'h30 + d;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 8'd10;
  endfunction

  task automatic send_code_unit(input logic [15:0] v);
    send_text(CH_BSLASH);
    send_text(CH_U);
    for (int i = 3; i >= 0; i--) send_text(hex_char(v[i * 4 +: 4]));
  endtask

  task automatic send_piece();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h7e;
        send_text(b);
      end
      2: begin
        send_text(CH_BSLASH);
        case ($urandom_range(0, 4))
          0: send_text(CH_B);
          1: send_text(CH_F);
          2: send_text(CH_N);
          3: send_text(CH_R);
          default: send_text(CH_T);
        endcase
      end
      3: begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_U) b = 8'h2f;
        send_text(CH_BSLASH);
        send_text(b);
      end
      4: send_code_unit(16'($urandom_range(0, 16'h7f)));
      5: send_code_unit(16'($urandom_range(16'h80, 16'h7ff)));
      6: send_code_unit(16'($urandom_range(16'h800, 16'hffff)));
      7: send_code_unit(16'($urandom_range(16'hd800, 16'hdfff)));
      8: begin
        send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
        send_code_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
      end
      default: begin
        send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
        send_code_unit(16'($urandom_range(0, 16'hffff)));
      end
    endcase
  endtask

  task automatic send_string();
    int         n;
    int         pick;
    logic [7:0] b;
    steady = ($urandom_range(0, 5) == 0);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_text(8'($urandom_range(0, 255)));
    end else if (pick == 1) begin
      send_end(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 2);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: send_text(CH_SPACE);
          1: send_text(CH_TAB);
          2: send_text(CH_LF);
          default: send_text(CH_CR);
        endcase
      end
      send_text(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) send_piece();
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        send_text(CH_QUOTE);
      end else if (pick < 18) begin
        send_text(CH_BSLASH);
        send_text(CH_U);
        n = $urandom_range(0, 3);
        repeat (n) send_text(hex_char(4'($urandom_range(0, 15))));
        do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
        send_text(b);
      end else if (pick == 18) begin
        send_end(8'($urandom_range(0, 255)));
      end else begin
        send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
        send_end(8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, due_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser, m_tlast};
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result: data %02h kind %0d last %0b",
                 $time, got.data, got.kind, got.last);
        errors++;
      end else begin
        want = due_q.pop_front();
        results_seen++;
        if (want.kind == jsu_pkg::KIND_DONE) strings_done++;
        if (got.data !== want.data) begin
          $display("%0t: data mismatch: expected %02h, actual %02h",
                   $time, want.data, got.data);
          errors++;
        end
        if (got.kind !== want.kind) begin
          $display("%0t: kind mismatch: expected %0d, actual %0d",
                   $time, want.kind, got.kind);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pause_cycles();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      send_byte(plan[i].code, plan[i].eoi);
      if (plan[i].typed) begin
        if (plan[i].one) due_q.push_back('{plan[i].xb, plan[i].xk, 1'b1});
      end else begin
        queue_step();
      end
    end

    while (bytes_sent < BYTE_TARGET) send_string();
    @(negedge clk);
    s_tvalid <= 1'b0;

    wait (due_q.size() == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes of JSON text: escapes, surrogate pairs and errors,",
             bytes_sent);
    $display("then random strings under random stalls on both sides.");
    $display("Checked %0d results, %0d of them closing a string.", results_seen, strings_done);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
